FILE: src/walt_pkg.sv
// walt_pkg: types, widths and codes shared by the log transaction tracker
// used by walt_ctrl, walt_dp, the top level and its checker
`default_nettype none

package walt_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 30;

  localparam int unsigned BLK_W     = 31;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned LB_W      = 16;
  localparam int unsigned OPS_W     = 8;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned ST_W      = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 31;

  typedef enum logic [REQ_W-1:0] {
    REQ_BEGIN = 2'd0,
    REQ_END   = 2'd1,
    REQ_LOG   = 2'd2
  } req_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS = 2'd0,
    KIND_COPY   = 2'd1,
    KIND_HEADER = 2'd2
  } kind_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_WAIT      = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_OUTSIDE   = 3'd3,
    ST_NO_BEGIN  = 3'd4
  } st_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOG_START  = 2'd0,
    CFG_LOG_BLOCKS = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SEL_REPLY   = 3'd0,
    SEL_COPY    = 3'd1,
    SEL_HDR_N   = 3'd2,
    SEL_INSTALL = 3'd3,
    SEL_HDR0    = 3'd4
  } out_sel_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'd0,
    S_LOOK  = 4'd1,
    S_REPLY = 4'd2,
    S_CP_RD = 4'd3,
    S_CP_EM = 4'd4,
    S_HDR_N = 4'd5,
    S_IN_RD = 4'd6,
    S_IN_EM = 4'd7,
    S_HDR0  = 4'd8
  } state_e;

  typedef struct packed {
    logic     take;
    logic     set_st;
    st_e      st;
    logic     pin;
    logic     inc_oo;
    logic     dec_oo;
    logic     look_step;
    logic     ram_wr;
    logic     ram_re;
    logic     idx_clr;
    logic     idx_inc;
    logic     clr_ec;
    logic     out_load;
    out_sel_e sel;
  } cmd_t;

  typedef struct packed {
    logic oo_zero;
    logic oo_one;
    logic ec_zero;
    logic too_large;
    logic match;
    logic miss;
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: src/walt_ram.sv
// walt_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`default_nettype none

module walt_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 30,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/walt_dp.sv
// walt_dp: datapath with config registers, counters, block table and result register
// depends on walt_pkg and walt_ram
`default_nettype none

module walt_dp #(
  parameter int unsigned MAX_ENTRIES = walt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [walt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [walt_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic [walt_pkg::BLK_W-1:0]      in_block_no_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic [walt_pkg::KIND_W-1:0]     out_kind_o,
  output logic [walt_pkg::ST_W-1:0]       out_status_o,
  output logic [walt_pkg::BLK_W-1:0]      out_source_block_o,
  output logic [walt_pkg::BLK_W-1:0]      out_dst_block_o,
  output logic [walt_pkg::CNT_W-1:0]      out_header_count_o,
  output logic                            out_pin_block_o,
  output logic                            out_unpin_block_o,
  output logic                            out_last_o,
  input  walt_pkg::cmd_t                  cmd_i,
  output walt_pkg::sts_t                  sts_o
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [walt_pkg::BLK_W-1:0] ls_q, ls_d;
  logic [walt_pkg::LB_W-1:0]  lb_q, lb_d;
  logic [walt_pkg::CNT_W-1:0] ec_q, ec_d;
  logic [walt_pkg::OPS_W-1:0] oo_q, oo_d;
  logic [walt_pkg::CNT_W-1:0] idx_q, idx_d;
  logic                       rv_q, rv_d;
  logic [walt_pkg::BLK_W-1:0] blk_q, blk_d;
  walt_pkg::st_e              st_q, st_d;
  logic                       pin_q, pin_d;

  logic                       ov_q, ov_d;
  walt_pkg::kind_e            okind_q, okind_d;
  walt_pkg::st_e              ost_q, ost_d;
  logic [walt_pkg::BLK_W-1:0] osrc_q, osrc_d;
  logic [walt_pkg::BLK_W-1:0] odst_q, odst_d;
  logic [walt_pkg::CNT_W-1:0] ohc_q, ohc_d;
  logic                       opin_q, opin_d;
  logic                       ounpin_q, ounpin_d;
  logic                       olast_q, olast_d;

  logic                       issue;
  logic                       ram_re;
  logic [walt_pkg::BLK_W-1:0] rdata;
  logic [walt_pkg::BLK_W-1:0] log_addr;
  logic                       cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  assign issue    = idx_q < ec_q;
  assign ram_re   = cmd_i.ram_re || (cmd_i.look_step && issue);
  assign log_addr = ls_q + walt_pkg::BLK_W'(idx_q) + walt_pkg::BLK_W'(1);

  walt_ram #(
    .WIDTH (walt_pkg::BLK_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_wr),
    .waddr_i (ec_q[AW-1:0]),
    .wdata_i (blk_q),
    .re_i    (ram_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // config and counters
  always_comb begin
    ls_d  = ls_q;
    lb_d  = lb_q;
    ec_d  = ec_q;
    oo_d  = oo_q;
    idx_d = idx_q;
    rv_d  = 1'b0;
    blk_d = blk_q;
    st_d  = st_q;
    pin_d = pin_q;
    if (cfg_wr) begin
      unique case (walt_pkg::cfg_idx_e'(cfg_index_i))
        walt_pkg::CFG_LOG_START:  ls_d = cfg_data_i[walt_pkg::BLK_W-1:0];
        walt_pkg::CFG_LOG_BLOCKS: lb_d = cfg_data_i[walt_pkg::LB_W-1:0];
        default: ;
      endcase
    end
    if (cmd_i.take) begin
      blk_d = in_block_no_i;
    end
    if (cmd_i.set_st) begin
      st_d  = cmd_i.st;
      pin_d = cmd_i.pin;
    end
    if (cmd_i.inc_oo && (oo_q != '1)) begin
      oo_d = oo_q + walt_pkg::OPS_W'(1);
    end
    if (cmd_i.dec_oo) begin
      oo_d = oo_q - walt_pkg::OPS_W'(1);
    end
    if (cmd_i.ram_wr) begin
      ec_d = ec_q + walt_pkg::CNT_W'(1);
    end
    if (cmd_i.clr_ec) begin
      ec_d = '0;
    end
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc || (cmd_i.look_step && issue)) begin
      idx_d = idx_q + walt_pkg::CNT_W'(1);
    end
    if (cmd_i.look_step) begin
      rv_d = issue;
    end
  end

  // result register
  always_comb begin
    ov_d     = ov_q && out_stall_i;
    okind_d  = okind_q;
    ost_d    = ost_q;
    osrc_d   = osrc_q;
    odst_d   = odst_q;
    ohc_d    = ohc_q;
    opin_d   = opin_q;
    ounpin_d = ounpin_q;
    olast_d  = olast_q;
    if (cmd_i.out_load) begin
      ov_d     = 1'b1;
      okind_d  = walt_pkg::KIND_STATUS;
      ost_d    = walt_pkg::ST_OK;
      osrc_d   = '0;
      odst_d   = '0;
      ohc_d    = '0;
      opin_d   = 1'b0;
      ounpin_d = 1'b0;
      olast_d  = 1'b0;
      unique case (cmd_i.sel)
        walt_pkg::SEL_REPLY: begin
          ost_d   = st_q;
          opin_d  = pin_q;
          olast_d = 1'b1;
        end
        walt_pkg::SEL_COPY: begin
          okind_d = walt_pkg::KIND_COPY;
          osrc_d  = rdata;
          odst_d  = log_addr;
        end
        walt_pkg::SEL_HDR_N: begin
          okind_d = walt_pkg::KIND_HEADER;
          ohc_d   = ec_q;
        end
        walt_pkg::SEL_INSTALL: begin
          okind_d  = walt_pkg::KIND_COPY;
          osrc_d   = log_addr;
          odst_d   = rdata;
          ounpin_d = 1'b1;
        end
        walt_pkg::SEL_HDR0: begin
          okind_d = walt_pkg::KIND_HEADER;
          olast_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ls_q  <= '0;
      lb_q  <= walt_pkg::LB_W'(31);
      ec_q  <= '0;
      oo_q  <= '0;
      idx_q <= '0;
      rv_q  <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      ls_q  <= ls_d;
      lb_q  <= lb_d;
      ec_q  <= ec_d;
      oo_q  <= oo_d;
      idx_q <= idx_d;
      rv_q  <= rv_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q    <= blk_d;
    st_q     <= st_d;
    pin_q    <= pin_d;
    okind_q  <= okind_d;
    ost_q    <= ost_d;
    osrc_q   <= osrc_d;
    odst_q   <= odst_d;
    ohc_q    <= ohc_d;
    opin_q   <= opin_d;
    ounpin_q <= ounpin_d;
    olast_q  <= olast_d;
  end

  assign sts_o.oo_zero   = (oo_q == '0);
  assign sts_o.oo_one    = (oo_q == walt_pkg::OPS_W'(1));
  assign sts_o.ec_zero   = (ec_q == '0);
  assign sts_o.too_large = (ec_q >= walt_pkg::CNT_W'(MAX_ENTRIES)) ||
                           (({{(walt_pkg::LB_W + 1 - walt_pkg::CNT_W){1'b0}}, ec_q}
                             + 17'd1) >= {1'b0, lb_q});
  assign sts_o.match     = rv_q && (rdata == blk_q);
  assign sts_o.miss      = !issue && !rv_q;
  assign sts_o.idx_last  = ((idx_q + walt_pkg::CNT_W'(1)) == ec_q);
  assign sts_o.out_free  = !ov_q || !out_stall_i;

  assign out_valid_o        = ov_q;
  assign out_kind_o         = okind_q;
  assign out_status_o       = ost_q;
  assign out_source_block_o = osrc_q;
  assign out_dst_block_o    = odst_q;
  assign out_header_count_o = ohc_q;
  assign out_pin_block_o    = opin_q;
  assign out_unpin_block_o  = ounpin_q;
  assign out_last_o         = olast_q;

endmodule

`default_nettype wire

FILE: src/walt_ctrl.sv
// walt_ctrl: request sequencer for lookup, reply and commit
// depends on walt_pkg
`default_nettype none

module walt_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [walt_pkg::REQ_W-1:0]  in_req_type_i,
  input  walt_pkg::sts_t              sts_i,
  output walt_pkg::cmd_t              cmd_o
);

  walt_pkg::state_e state_q, state_d;
  logic             can_begin;
  logic             commit;

  assign can_begin  = sts_i.ec_zero && sts_i.oo_zero;
  assign commit     = sts_i.oo_one && !sts_i.ec_zero;
  assign in_stall_o = (state_q != walt_pkg::S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      walt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (walt_pkg::req_e'(in_req_type_i))
            walt_pkg::REQ_BEGIN: state_d = walt_pkg::S_REPLY;
            walt_pkg::REQ_LOG: begin
              if (sts_i.too_large || sts_i.oo_zero) begin
                state_d = walt_pkg::S_REPLY;
              end else begin
                state_d = walt_pkg::S_LOOK;
              end
            end
            walt_pkg::REQ_END: begin
              if (!sts_i.oo_zero && commit) begin
                state_d = walt_pkg::S_CP_RD;
              end else begin
                state_d = walt_pkg::S_REPLY;
              end
            end
            default: ;
          endcase
        end
      end
      walt_pkg::S_LOOK: begin
        if (sts_i.match || sts_i.miss) begin
          state_d = walt_pkg::S_REPLY;
        end
      end
      walt_pkg::S_REPLY: begin
        if (sts_i.out_free) begin
          state_d = walt_pkg::S_IDLE;
        end
      end
      walt_pkg::S_CP_RD: state_d = walt_pkg::S_CP_EM;
      walt_pkg::S_CP_EM: begin
        if (sts_i.out_free) begin
          state_d = sts_i.idx_last ? walt_pkg::S_HDR_N : walt_pkg::S_CP_RD;
        end
      end
      walt_pkg::S_HDR_N: begin
        if (sts_i.out_free) begin
          state_d = walt_pkg::S_IN_RD;
        end
      end
      walt_pkg::S_IN_RD: state_d = walt_pkg::S_IN_EM;
      walt_pkg::S_IN_EM: begin
        if (sts_i.out_free) begin
          state_d = sts_i.idx_last ? walt_pkg::S_HDR0 : walt_pkg::S_IN_RD;
        end
      end
      walt_pkg::S_HDR0: begin
        if (sts_i.out_free) begin
          state_d = walt_pkg::S_IDLE;
        end
      end
      default: state_d = walt_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      walt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          unique case (walt_pkg::req_e'(in_req_type_i))
            walt_pkg::REQ_BEGIN: begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = can_begin ? walt_pkg::ST_OK : walt_pkg::ST_WAIT;
              cmd_o.inc_oo = can_begin;
            end
            walt_pkg::REQ_LOG: begin
              if (sts_i.too_large) begin
                cmd_o.set_st = 1'b1;
                cmd_o.st     = walt_pkg::ST_TOO_LARGE;
              end else if (sts_i.oo_zero) begin
                cmd_o.set_st = 1'b1;
                cmd_o.st     = walt_pkg::ST_OUTSIDE;
              end else begin
                cmd_o.idx_clr = 1'b1;
              end
            end
            walt_pkg::REQ_END: begin
              if (sts_i.oo_zero) begin
                cmd_o.set_st = 1'b1;
                cmd_o.st     = walt_pkg::ST_NO_BEGIN;
              end else begin
                cmd_o.dec_oo = 1'b1;
                if (commit) begin
                  cmd_o.idx_clr = 1'b1;
                end else begin
                  cmd_o.set_st = 1'b1;
                  cmd_o.st     = walt_pkg::ST_OK;
                end
              end
            end
            default: ;
          endcase
        end
      end
      walt_pkg::S_LOOK: begin
        cmd_o.look_step = 1'b1;
        if (sts_i.match) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = walt_pkg::ST_OK;
        end else if (sts_i.miss) begin
          cmd_o.ram_wr = 1'b1;
          cmd_o.set_st = 1'b1;
          cmd_o.st     = walt_pkg::ST_OK;
          cmd_o.pin    = 1'b1;
        end
      end
      walt_pkg::S_REPLY: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.sel      = walt_pkg::SEL_REPLY;
      end
      walt_pkg::S_CP_RD: cmd_o.ram_re = 1'b1;
      walt_pkg::S_CP_EM: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.sel      = walt_pkg::SEL_COPY;
        cmd_o.idx_clr  = sts_i.out_free && sts_i.idx_last;
        cmd_o.idx_inc  = sts_i.out_free && !sts_i.idx_last;
      end
      walt_pkg::S_HDR_N: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.sel      = walt_pkg::SEL_HDR_N;
      end
      walt_pkg::S_IN_RD: cmd_o.ram_re = 1'b1;
      walt_pkg::S_IN_EM: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.sel      = walt_pkg::SEL_INSTALL;
        cmd_o.idx_clr  = sts_i.out_free && sts_i.idx_last;
        cmd_o.idx_inc  = sts_i.out_free && !sts_i.idx_last;
      end
      walt_pkg::S_HDR0: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.sel      = walt_pkg::SEL_HDR0;
        cmd_o.clr_ec   = sts_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= walt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/write_ahead_log_transaction_tracker_top.sv
// write_ahead_log_transaction_tracker_top: log transaction tracker top level
// depends on walt_pkg, walt_ctrl, walt_dp and walt_ram
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_stall    req_type, block_no
//   out      source     out_valid/out_stall  kind, status, src/dst, header_count, flags
//   cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// begin, non-committing end and rejected writes: reply loaded in S_REPLY once the output is free
// logged write: S_LOOK scans the table, one table read per cycle, then S_REPLY loads the reply
// commit: copies to the log, count header, copies back, closing header; one table read per copy
// reset clears counters and control; the block table needs no clearing
// a stalled result holds the sequencer, the next item is taken once it reaches idle
`default_nettype none

module write_ahead_log_transaction_tracker_top #(
  parameter int unsigned MAX_ENTRIES = walt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [walt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [walt_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [walt_pkg::REQ_W-1:0]      in_req_type_i,
  input  logic [walt_pkg::BLK_W-1:0]      in_block_no_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [walt_pkg::KIND_W-1:0]     out_kind_o,
  output logic [walt_pkg::ST_W-1:0]       out_status_o,
  output logic [walt_pkg::BLK_W-1:0]      out_source_block_o,
  output logic [walt_pkg::BLK_W-1:0]      out_dst_block_o,
  output logic [walt_pkg::CNT_W-1:0]      out_header_count_o,
  output logic                            out_pin_block_o,
  output logic                            out_unpin_block_o,
  output logic                            out_last_o
);

  walt_pkg::cmd_t cmd;
  walt_pkg::sts_t sts;

  walt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_req_type_i (in_req_type_i),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  walt_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_block_no_i      (in_block_no_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .out_kind_o         (out_kind_o),
    .out_status_o       (out_status_o),
    .out_source_block_o (out_source_block_o),
    .out_dst_block_o    (out_dst_block_o),
    .out_header_count_o (out_header_count_o),
    .out_pin_block_o    (out_pin_block_o),
    .out_unpin_block_o  (out_unpin_block_o),
    .out_last_o         (out_last_o),
    .cmd_i              (cmd),
    .sts_o              (sts)
  );

endmodule

`default_nettype wire

FILE: src/walt_checker.sv
// walt_checker: port-level assertions for the log transaction tracker
// depends on walt_pkg, bound to write_ahead_log_transaction_tracker_top
`default_nettype none

module walt_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic [walt_pkg::REQ_W-1:0]      in_req_type_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [walt_pkg::KIND_W-1:0]     out_kind_o,
  input logic [walt_pkg::ST_W-1:0]       out_status_o,
  input logic [walt_pkg::BLK_W-1:0]      out_source_block_o,
  input logic [walt_pkg::BLK_W-1:0]      out_dst_block_o,
  input logic [walt_pkg::CNT_W-1:0]      out_header_count_o,
  input logic                            out_pin_block_o,
  input logic                            out_unpin_block_o,
  input logic                            out_last_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_kind_o) &&
      $stable(out_status_o) && $stable(out_source_block_o) && $stable(out_dst_block_o) &&
      $stable(out_header_count_o) && $stable(out_last_o))
    else $error("stalled result changed");

  // a request that yields results keeps the input side busy
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
      (in_req_type_i == walt_pkg::REQ_BEGIN || in_req_type_i == walt_pkg::REQ_END ||
       in_req_type_i == walt_pkg::REQ_LOG) |=> in_stall_o)
    else $error("input taken again before the reply");

  // status replies and the closing header end their item
  a_reply_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o == walt_pkg::KIND_STATUS ||
      (out_kind_o == walt_pkg::KIND_HEADER && out_header_count_o == '0)) |-> out_last_o)
    else $error("reply or header clear without last");

  // pin only on ok replies, unpin only on copies
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_pin_block_o || (out_kind_o == walt_pkg::KIND_STATUS &&
      out_status_o == walt_pkg::ST_OK)) &&
      (!out_unpin_block_o || out_kind_o == walt_pkg::KIND_COPY))
    else $error("pin or unpin on wrong result");

endmodule

bind write_ahead_log_transaction_tracker_top walt_checker u_walt_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .in_req_type_i      (in_req_type_i),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .out_kind_o         (out_kind_o),
  .out_status_o       (out_status_o),
  .out_source_block_o (out_source_block_o),
  .out_dst_block_o    (out_dst_block_o),
  .out_header_count_o (out_header_count_o),
  .out_pin_block_o    (out_pin_block_o),
  .out_unpin_block_o  (out_unpin_block_o),
  .out_last_o         (out_last_o)
);

`default_nettype wire

FILE: tb/walt_checker.sv
// walt_tb_checker: watches the config, request and result channels of the log tracker,
// predicts every result from its own copy of the log table and compares field by field
// depends on walt_pkg
`default_nettype none

module walt_tb_checker #(
  parameter int unsigned MAX_ENTRIES = walt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [walt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [walt_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [walt_pkg::REQ_W-1:0]     in_req_type_i,
  input  logic [walt_pkg::BLK_W-1:0]     in_block_no_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [walt_pkg::KIND_W-1:0]    out_kind_i,
  input  logic [walt_pkg::ST_W-1:0]      out_status_i,
  input  logic [walt_pkg::BLK_W-1:0]     out_source_block_i,
  input  logic [walt_pkg::BLK_W-1:0]     out_dst_block_i,
  input  logic [walt_pkg::CNT_W-1:0]     out_header_count_i,
  input  logic                           out_pin_block_i,
  input  logic                           out_unpin_block_i,
  input  logic                           out_last_i,
  output int                             mismatch_count_o,
  output int                             results_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [walt_pkg::LB_W-1:0] LOG_BLOCKS_RST = walt_pkg::LB_W'(31);

  typedef struct packed {
    logic [walt_pkg::KIND_W-1:0] kind;
    logic [walt_pkg::ST_W-1:0]   status;
    logic [walt_pkg::BLK_W-1:0]  src;
    logic [walt_pkg::BLK_W-1:0]  dst;
    logic [walt_pkg::CNT_W-1:0]  hdr_cnt;
    logic                        pin;
    logic                        unpin;
    logic                        last;
  } wal_result_t;

  logic [walt_pkg::BLK_W-1:0] log_start;
  logic [walt_pkg::LB_W-1:0]  log_blocks;
  logic [walt_pkg::BLK_W-1:0] blk_table [MAX_ENTRIES];
  int unsigned                entry_cnt;
  int unsigned                open_cnt;
  wal_result_t                owed_results [$];
  wal_result_t                want_r;
  wal_result_t                got_r;
  int                         mismatches;

  function automatic wal_result_t make_result(
    input logic [walt_pkg::KIND_W-1:0] kind,
    input logic [walt_pkg::ST_W-1:0]   status,
    input logic [walt_pkg::BLK_W-1:0]  src,
    input logic [walt_pkg::BLK_W-1:0]  dst,
    input logic [walt_pkg::CNT_W-1:0]  hdr_cnt,
    input logic                        pin,
    input logic                        unpin,
    input logic                        last
  );
    wal_result_t r;
    r.kind    = kind;
    r.status  = status;
    r.src     = src;
    r.dst     = dst;
    r.hdr_cnt = hdr_cnt;
    r.pin     = pin;
    r.unpin   = unpin;
    r.last    = last;
    return r;
  endfunction

  function automatic wal_result_t status_reply(input logic [walt_pkg::ST_W-1:0] status,
                                               input logic pin);
    return make_result(walt_pkg::KIND_STATUS, status, '0, '0, '0, pin, 1'b0, 1'b1);
  endfunction

  task automatic track_request(input logic [walt_pkg::REQ_W-1:0] req,
                               input logic [walt_pkg::BLK_W-1:0] blk);
    int unsigned                i;
    logic                       found;
    logic [walt_pkg::BLK_W-1:0] area;
    case (req)
      walt_pkg::REQ_BEGIN: begin
        if (entry_cnt + (open_cnt + 1) * MAX_ENTRIES > MAX_ENTRIES) begin
          owed_results.push_back(status_reply(walt_pkg::ST_WAIT, 1'b0));
        end else begin
          if (open_cnt < 255) open_cnt++;
          owed_results.push_back(status_reply(walt_pkg::ST_OK, 1'b0));
        end
      end
      walt_pkg::REQ_LOG: begin
        if (entry_cnt >= MAX_ENTRIES || int'(entry_cnt) >= int'(log_blocks) - 1) begin
          owed_results.push_back(status_reply(walt_pkg::ST_TOO_LARGE, 1'b0));
        end else if (open_cnt == 0) begin
          owed_results.push_back(status_reply(walt_pkg::ST_OUTSIDE, 1'b0));
        end else begin
          found = 1'b0;
          for (i = 0; i < entry_cnt; i++) begin
            if (blk_table[i] == blk) found = 1'b1;
          end
          if (!found) begin
            blk_table[entry_cnt] = blk;
            entry_cnt++;
          end
          owed_results.push_back(status_reply(walt_pkg::ST_OK, !found));
        end
      end
      walt_pkg::REQ_END: begin
        if (open_cnt == 0) begin
          owed_results.push_back(status_reply(walt_pkg::ST_NO_BEGIN, 1'b0));
        end else begin
          open_cnt--;
          if (open_cnt != 0 || entry_cnt == 0) begin
            owed_results.push_back(status_reply(walt_pkg::ST_OK, 1'b0));
          end else begin
            for (i = 0; i < entry_cnt; i++) begin
              area = log_start + walt_pkg::BLK_W'(i + 1);
              owed_results.push_back(make_result(walt_pkg::KIND_COPY, walt_pkg::ST_OK,
                                                 blk_table[i], area,
                                                 '0, 1'b0, 1'b0, 1'b0));
            end
            owed_results.push_back(make_result(walt_pkg::KIND_HEADER, walt_pkg::ST_OK,
                                               '0, '0, walt_pkg::CNT_W'(entry_cnt),
                                               1'b0, 1'b0, 1'b0));
            for (i = 0; i < entry_cnt; i++) begin
              area = log_start + walt_pkg::BLK_W'(i + 1);
              owed_results.push_back(make_result(walt_pkg::KIND_COPY, walt_pkg::ST_OK,
                                                 area, blk_table[i],
                                                 '0, 1'b0, 1'b1, 1'b0));
            end
            owed_results.push_back(make_result(walt_pkg::KIND_HEADER, walt_pkg::ST_OK,
                                               '0, '0, '0, 1'b0, 1'b0, 1'b1));
            entry_cnt = 0;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t result field %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_start  = '0;
      log_blocks = LOG_BLOCKS_RST;
      entry_cnt  = 0;
      open_cnt   = 0;
      mismatches = 0;
      owed_results.delete();
      mismatch_count_o <= 0;
      results_owed_o   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          walt_pkg::CFG_LOG_START:  log_start  = cfg_data_i[walt_pkg::BLK_W-1:0];
          walt_pkg::CFG_LOG_BLOCKS: log_blocks = cfg_data_i[walt_pkg::LB_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) track_request(in_req_type_i, in_block_no_i);
      if (out_valid_i && !out_stall_i) begin
        got_r = make_result(out_kind_i, out_status_i, out_source_block_i, out_dst_block_i,
                            out_header_count_i, out_pin_block_i, out_unpin_block_i,
                            out_last_i);
        if (owed_results.size() == 0) begin
          $display("%0t result expected none actual kind 0x%0h status 0x%0h src 0x%0h dst 0x%0h",
                   $time, got_r.kind, got_r.status, got_r.src, got_r.dst);
          mismatches++;
        end else begin
          want_r = owed_results.pop_front();
          check_field("kind", want_r.kind, got_r.kind);
          check_field("status", want_r.status, got_r.status);
          check_field("source_block", want_r.src, got_r.src);
          check_field("dst_block", want_r.dst, got_r.dst);
          check_field("header_count", want_r.hdr_cnt, got_r.hdr_cnt);
          check_field("pin_block", want_r.pin, got_r.pin);
          check_field("unpin_block", want_r.unpin, got_r.unpin);
          check_field("last", want_r.last, got_r.last);
        end
      end
      mismatch_count_o <= mismatches;
      results_owed_o   <= owed_results.size();
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// tb_top: clock, reset and stimulus for the log transaction tracker, plus the verdict
// drives directed and random transactions through phases of log settings
// depends on walt_pkg, walt_tb_checker and write_ahead_log_transaction_tracker_top
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [walt_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int                         HOLD_CYCLES = 300;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [walt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [walt_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [walt_pkg::REQ_W-1:0]     in_req = '0;
  logic [walt_pkg::BLK_W-1:0]     in_block = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [walt_pkg::KIND_W-1:0]    out_kind;
  logic [walt_pkg::ST_W-1:0]      out_status;
  logic [walt_pkg::BLK_W-1:0]     out_src;
  logic [walt_pkg::BLK_W-1:0]     out_dst;
  logic [walt_pkg::CNT_W-1:0]     out_hdr_cnt;
  logic                           out_pin;
  logic                           out_unpin;
  logic                           out_last;
  int                             mismatch_count;
  int                             results_owed;

  logic                           calm = 1'b0;
  logic                           hold_req = 1'b0;
  int unsigned                    items_sent = 0;
  logic [walt_pkg::BLK_W-1:0]     block_pool [8];

  always #5ns clk = ~clk;

  write_ahead_log_transaction_tracker_top i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .in_req_type_i      (in_req),
    .in_block_no_i      (in_block),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .out_kind_o         (out_kind),
    .out_status_o       (out_status),
    .out_source_block_o (out_src),
    .out_dst_block_o    (out_dst),
    .out_header_count_o (out_hdr_cnt),
    .out_pin_block_o    (out_pin),
    .out_unpin_block_o  (out_unpin),
    .out_last_o         (out_last)
  );

  walt_tb_checker i_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .in_req_type_i      (in_req),
    .in_block_no_i      (in_block),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .out_kind_i         (out_kind),
    .out_status_i       (out_status),
    .out_source_block_i (out_src),
    .out_dst_block_i    (out_dst),
    .out_header_count_i (out_hdr_cnt),
    .out_pin_block_i    (out_pin),
    .out_unpin_block_i  (out_unpin),
    .out_last_i         (out_last),
    .mismatch_count_o   (mismatch_count),
    .results_owed_o     (results_owed)
  );

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall = !calm && ($urandom_range(99) < 19);
    end
  end

  task automatic send_request(input logic [walt_pkg::REQ_W-1:0] req,
                              input logic [walt_pkg::BLK_W-1:0] blk);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_req   = req;
    in_block = blk;
    do @(posedge clk); while (in_stall);
    if (req != REQ_UNUSED) items_sent++;
  endtask

  task automatic write_reg(input walt_pkg::cfg_idx_e idx,
                           input logic [walt_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // sender pauses until every owed result has come out
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_log_area(input logic [walt_pkg::BLK_W-1:0] start,
                              input logic [walt_pkg::LB_W-1:0] blocks);
    drain();
    if ($urandom_range(1)) begin
      write_reg(walt_pkg::CFG_LOG_START, walt_pkg::CFG_W'(start));
      write_reg(walt_pkg::CFG_LOG_BLOCKS, walt_pkg::CFG_W'(blocks));
    end else begin
      write_reg(walt_pkg::CFG_LOG_BLOCKS, walt_pkg::CFG_W'(blocks));
      write_reg(walt_pkg::CFG_LOG_START, walt_pkg::CFG_W'(start));
    end
  endtask

  function automatic logic [walt_pkg::BLK_W-1:0] pick_block();
    if ($urandom_range(9) < 6) return block_pool[$urandom_range(7)];
    return walt_pkg::BLK_W'($urandom);
  endfunction

  task automatic run_transaction(input int unsigned n_writes);
    int unsigned i;
    send_request(walt_pkg::REQ_BEGIN, pick_block());
    for (i = 0; i < n_writes; i++) begin
      if ($urandom_range(19) == 0) send_request(walt_pkg::REQ_BEGIN, pick_block());
      send_request(walt_pkg::REQ_LOG, pick_block());
    end
    if ($urandom_range(9) == 0) send_request(REQ_UNUSED, pick_block());
    send_request(walt_pkg::REQ_END, pick_block());
  endtask

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned                ph;
    int unsigned                k;
    int unsigned                target;
    logic [walt_pkg::BLK_W-1:0] start;
    logic [walt_pkg::LB_W-1:0]  blocks;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed
    write_reg(walt_pkg::CFG_LOG_START, walt_pkg::CFG_W'(100));
    write_reg(walt_pkg::CFG_LOG_BLOCKS, walt_pkg::CFG_W'(31));
    send_request(walt_pkg::REQ_END, '0);
    send_request(walt_pkg::REQ_LOG, walt_pkg::BLK_W'(5));
    send_request(REQ_UNUSED, '1);
    send_request(walt_pkg::REQ_BEGIN, '0);
    send_request(walt_pkg::REQ_BEGIN, '1);
    send_request(walt_pkg::REQ_LOG, '0);
    send_request(walt_pkg::REQ_LOG, '1);
    send_request(walt_pkg::REQ_LOG, '0);
    send_request(walt_pkg::REQ_END, '1);
    send_request(walt_pkg::REQ_BEGIN, '0);
    send_request(walt_pkg::REQ_END, '0);
    // smallest log area, commit address wraps past the top
    set_log_area('1, walt_pkg::LB_W'(2));
    send_request(walt_pkg::REQ_BEGIN, '0);
    send_request(walt_pkg::REQ_LOG, walt_pkg::BLK_W'(7));
    send_request(walt_pkg::REQ_LOG, walt_pkg::BLK_W'(9));
    send_request(walt_pkg::REQ_LOG, walt_pkg::BLK_W'(7));
    send_request(walt_pkg::REQ_END, '0);

    // random phases
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin start = '0; blocks = walt_pkg::LB_W'(31); end
        1: begin start = walt_pkg::BLK_W'($urandom); blocks = '1; end
        2: begin start = walt_pkg::BLK_W'(32'h7fff_fff0); blocks = walt_pkg::LB_W'(20); end
        3: begin start = walt_pkg::BLK_W'($urandom); blocks = walt_pkg::LB_W'(3); end
        4: begin start = '1; blocks = walt_pkg::LB_W'(2); end
        default: begin
          start  = walt_pkg::BLK_W'($urandom);
          blocks = walt_pkg::LB_W'($urandom_range(40, 2));
        end
      endcase
      set_log_area(start, blocks);
      calm = (ph == 2);
      block_pool[0] = '0;
      block_pool[1] = '1;
      for (k = 2; k < 8; k++) block_pool[k] = walt_pkg::BLK_W'($urandom);
      if (ph == 1) begin
        hold_req = 1'b1;
        run_transaction(34);
      end
      target = items_sent + 16;
      while (items_sent < target) begin
        if ($urandom_range(4) == 0)
          send_request(walt_pkg::REQ_W'($urandom_range(REQ_UNUSED)),
                       walt_pkg::BLK_W'($urandom));
        else if ($urandom_range(4) == 0)
          run_transaction($urandom_range(34, 20));
        else
          run_transaction($urandom_range(6));
      end
    end
    calm = 1'b0;

    drain();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
